// File: hw/rtl/pgwd_pkg.sv
// Package: shared types and constants for the pixel gain, white balance and dither unit.
`timescale 1ns / 1ps
package pgwd_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC      = 12;
  localparam int DIM_W     = 13;
  localparam int CNT_W     = 12;
  localparam int NUM_W     = 25;
  localparam int XD_W      = NUM_W + 1;
  localparam int P1_W      = XD_W + 16;
  localparam int T_W       = P1_W - FRAC + 1;
  localparam int TX_W      = XD_W + T_W;
  localparam int C_W       = TX_W - FRAC + 2;
  localparam int VC_W      = C_W + 9;
  localparam int PR_W      = VC_W + 16;
  localparam int VAL_W     = PR_W - 2 * FRAC + 8 + 2;
  localparam int RES_W     = 10;
  localparam int QDEPTH    = 4;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_COLOR_MODE      = 3'd2,
    REG_GAIN_CONSTANT   = 3'd3,
    REG_GAIN_X_TERMS    = 3'd4,
    REG_GAIN_Y_TERMS    = 3'd5,
    REG_CHANNEL_GAINS   = 3'd6,
    REG_CHANNEL_OFFSETS = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic              color_mode;
    logic [15:0]       gain_constant;
    logic [31:0]       gain_x_terms;
    logic [31:0]       gain_y_terms;
    logic [47:0]       channel_gains;
    logic [47:0]       channel_offsets;
  } cfg_t;

  typedef struct packed {
    logic signed [XD_W-1:0] xd;
    logic signed [XD_W-1:0] yd;
    logic [23:0]            pix;
    logic                   last;
  } item_t;

endpackage

// File: hw/rtl/pgwd_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pgwd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pgwd_pkg::NUM_W-1:0]    num,
  input  logic [pgwd_pkg::DIM_W-1:0]    den,
  output logic                          running,
  output logic                          done,
  output logic [pgwd_pkg::NUM_W-1:0]    quot,
  output logic [pgwd_pkg::DIM_W-1:0]    rem
);
  logic [pgwd_pkg::NUM_W-1:0] acc;
  logic [pgwd_pkg::DIM_W-1:0] r;
  logic [pgwd_pkg::DIM_W-1:0] d;
  logic [4:0]                 cnt;
  logic [pgwd_pkg::DIM_W:0]   trial;

  assign trial = {r, acc[pgwd_pkg::NUM_W-1]};
  assign quot  = acc;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(pgwd_pkg::NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      r   <= '0;
      d   <= den;
    end else if (running) begin
      if (trial >= {1'b0, d}) begin
        r   <= pgwd_pkg::DIM_W'(trial - {1'b0, d});
        acc <= {acc[pgwd_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r   <= trial[pgwd_pkg::DIM_W-1:0];
        acc <= {acc[pgwd_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

// File: hw/rtl/pgwd_front.sv
// Front end: position counters and incremental normalized coordinates.
`timescale 1ns / 1ps
module pgwd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  pgwd_pkg::cfg_t       cfg,
  input  logic                 cfg_write,
  input  logic                 in_valid,
  input  logic [23:0]          in_pix,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 push,
  output pgwd_pkg::item_t      item
);
  localparam int DW = pgwd_pkg::DIM_W;
  localparam int NW = pgwd_pkg::NUM_W;
  localparam logic signed [pgwd_pkg::XD_W-1:0] XD_HALF =
    pgwd_pkg::XD_W'(1 << (pgwd_pkg::FRAC - 1));

  logic [DW-1:0] weff, heff;
  logic [pgwd_pkg::CNT_W-1:0] x, y;
  logic [NW-1:0] qx, qy, dqx, dqy;
  logic [DW-1:0] rx, ry, drx, dry;
  logic pending;
  logic run [4];
  logic dn [4];
  logic [NW-1:0] dq [4];
  logic [DW-1:0] dr [4];
  logic [NW-1:0] dnum [4];
  logic [DW-1:0] dden [4];
  logic last, row_wrap;
  logic [DW:0] rxs, rys;

  function automatic logic [DW-1:0] clampdim(input logic [DW-1:0] v);
    if (v == '0) return DW'(1);
    if (v > DW'(pgwd_pkg::MAX_DIM)) return DW'(pgwd_pkg::MAX_DIM);
    return v;
  endfunction

  assign weff = clampdim(cfg.image_width);
  assign heff = clampdim(cfg.image_height);

  assign dnum[0] = NW'({x, pgwd_pkg::FRAC'(0)});
  assign dnum[1] = NW'({y, pgwd_pkg::FRAC'(0)});
  assign dnum[2] = NW'(1 << pgwd_pkg::FRAC);
  assign dnum[3] = NW'(1 << pgwd_pkg::FRAC);
  assign dden[0] = weff;
  assign dden[1] = heff;
  assign dden[2] = weff;
  assign dden[3] = heff;

  for (genvar i = 0; i < 4; i++) begin : g_div
    pgwd_div u_div (
      .clk(clk), .rst(rst), .start(pending), .num(dnum[i]), .den(dden[i]),
      .running(run[i]), .done(dn[i]), .quot(dq[i]), .rem(dr[i])
    );
  end

  assign in_ready = !pending && !run[0] && !dn[0] && !q_full;
  assign push     = in_valid && in_ready;

  assign last     = ({1'b0, x} + 13'd1) >= weff;
  assign row_wrap = ({1'b0, y} + 13'd1) >= heff;
  assign rxs      = {1'b0, rx} + {1'b0, drx};
  assign rys      = {1'b0, ry} + {1'b0, dry};

  assign item.xd   = $signed({1'b0, qx}) - XD_HALF;
  assign item.yd   = $signed({1'b0, qy}) - XD_HALF;
  assign item.pix  = in_pix;
  assign item.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b1;
      x       <= '0;
      y       <= '0;
    end else begin
      if (cfg_write) pending <= 1'b1;
      else if (pending) pending <= 1'b0;
      if (push) begin
        if (last) begin
          x <= '0;
          y <= row_wrap ? '0 : y + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dn[0]) begin
      qx  <= dq[0];  rx  <= dr[0];
      qy  <= dq[1];  ry  <= dr[1];
      dqx <= dq[2];  drx <= dr[2];
      dqy <= dq[3];  dry <= dr[3];
    end else if (push) begin
      if (last) begin
        qx <= '0;
        rx <= '0;
        if (row_wrap) begin
          qy <= '0;
          ry <= '0;
        end else if (rys >= {1'b0, heff}) begin
          qy <= qy + dqy + 1'b1;
          ry <= DW'(rys - {1'b0, heff});
        end else begin
          qy <= qy + dqy;
          ry <= rys[DW-1:0];
        end
      end else if (rxs >= {1'b0, weff}) begin
        qx <= qx + dqx + 1'b1;
        rx <= DW'(rxs - {1'b0, weff});
      end else begin
        qx <= qx + dqx;
        rx <= rxs[DW-1:0];
      end
    end
  end
endmodule

// File: hw/rtl/pgwd_queue.sv
// Small FIFO between front and back.
`timescale 1ns / 1ps
module pgwd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pgwd_pkg::item_t   din,
  input  logic              pop,
  output pgwd_pkg::item_t   dout,
  output logic              full,
  output logic              nonempty,
  output logic [2:0]        count
);
  pgwd_pkg::item_t mem [pgwd_pkg::QDEPTH];
  logic [1:0] wp, rp;

  assign full     = count == 3'(pgwd_pkg::QDEPTH);
  assign nonempty = count != 3'd0;
  assign dout     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end
endmodule

// File: hw/rtl/pgwd_back.sv
// Back end: gain polynomial, per-channel scaling in color mode and error diffusion dither.
`timescale 1ns / 1ps
module pgwd_back (
  input  logic              clk,
  input  logic              rst,
  input  pgwd_pkg::cfg_t    cfg,
  input  logic              q_nonempty,
  input  pgwd_pkg::item_t   q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [23:0]       out_pix,
  output logic              out_last
);
  localparam int F = pgwd_pkg::FRAC;

  logic adv;
  logic [5:0] v;
  logic [23:0] pix [6];
  logic        lst [6];

  logic signed [pgwd_pkg::XD_W-1:0]  xd1, yd1;
  logic signed [pgwd_pkg::P1_W-1:0]  p1x, p1y;
  logic signed [pgwd_pkg::TX_W-1:0]  tx, ty;
  logic signed [pgwd_pkg::C_W-1:0]   c;
  logic signed [pgwd_pkg::VC_W-1:0]  vc [3];
  logic signed [pgwd_pkg::PR_W-1:0]  pr [3];
  logic signed [pgwd_pkg::VAL_W-1:0] val [3];
  logic signed [pgwd_pkg::RES_W-1:0] res [3];

  logic signed [pgwd_pkg::T_W-1:0]   t_x, t_y;
  logic signed [pgwd_pkg::VAL_W-1:0] s [3];
  logic [pgwd_pkg::VAL_W-1:0]        mag [3];
  logic [7:0]                        q8 [3];
  logic signed [pgwd_pkg::RES_W-1:0] rnew [3];

  assign adv = !out_valid || out_ready;
  assign pop = adv && q_nonempty;

  assign t_x = pgwd_pkg::T_W'($signed(cfg.gain_x_terms[15:0])) + pgwd_pkg::T_W'(p1x >>> F);
  assign t_y = pgwd_pkg::T_W'($signed(cfg.gain_y_terms[15:0])) + pgwd_pkg::T_W'(p1y >>> F);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s[k]   = val[k] + pgwd_pkg::VAL_W'(res[k]);
      mag[k] = s[k][pgwd_pkg::VAL_W-1] ? pgwd_pkg::VAL_W'(-s[k]) : pgwd_pkg::VAL_W'(s[k]);
      if (s[k][pgwd_pkg::VAL_W-1]) q8[k] = 8'd0;
      else if (mag[k][pgwd_pkg::VAL_W-1:8] > 255) q8[k] = 8'd255;
      else q8[k] = mag[k][15:8];
      rnew[k] = s[k][pgwd_pkg::VAL_W-1] ? -$signed({2'b00, mag[k][7:0]})
                                         : $signed({2'b00, mag[k][7:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) res[k] <= '0;
    end else if (adv) begin
      v         <= {v[4:0], q_nonempty};
      out_valid <= v[5];
      if (v[5]) begin
        if (lst[5]) begin
          for (int k = 0; k < 3; k++) res[k] <= '0;
        end else if (cfg.color_mode) begin
          for (int k = 0; k < 3; k++) res[k] <= rnew[k];
        end else begin
          res[0] <= rnew[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xd1    <= q_item.xd;
      yd1    <= q_item.yd;
      pix[0] <= q_item.pix;
      lst[0] <= q_item.last;
      p1x    <= $signed(cfg.gain_x_terms[31:16]) * q_item.xd;
      p1y    <= $signed(cfg.gain_y_terms[31:16]) * q_item.yd;
      tx  <= xd1 * t_x;
      ty  <= yd1 * t_y;
      c   <= pgwd_pkg::C_W'($signed(cfg.gain_constant)) + pgwd_pkg::C_W'(tx >>> F)
           + pgwd_pkg::C_W'(ty >>> F);
      for (int k = 0; k < 3; k++) begin
        vc[k] <= $signed({1'b0, pix[2][8*k +: 8]}) * c;
        pr[k] <= cfg.color_mode ? $signed(cfg.channel_gains[16*k +: 16]) * vc[k]
                                : pgwd_pkg::PR_W'(vc[k]) <<< F;
        val[k] <= pgwd_pkg::VAL_W'(pr[k] >>> (2 * F - 8))
                + (cfg.color_mode ?
                   pgwd_pkg::VAL_W'($signed({cfg.channel_offsets[16*k +: 16], 1'b0})) :
                   pgwd_pkg::VAL_W'(0));
      end
      for (int i = 1; i < 6; i++) begin
        pix[i] <= pix[i-1];
        lst[i] <= lst[i-1];
      end
      if (v[5]) begin
        out_pix[7:0]   <= q8[0];
        out_pix[15:8]  <= cfg.color_mode ? q8[1] : 8'd0;
        out_pix[23:16] <= cfg.color_mode ? q8[2] : 8'd0;
        out_last       <= lst[5];
      end
    end
  end
endmodule

// File: hw/rtl/pixel_gain_whitebalance_dither_unit.sv
// Top level: pixel gain, white balance and dither unit.
//  channel   dir  request fields
//  s_axis    in   tdata = blue, green, red
//  m_axis    out  tdata = blue, green, red; tlast = end_of_row
//  cfg       in   cfg_index, cfg_data
// One pixel per clock once the coordinate dividers are done and while m_axis_tready
// is high. After every config write, and after reset, the dividers hold s_axis_tready
// low until they finish. A 4-entry queue decouples counters from the datapath.
// Reset rst is synchronous; output stalls back up through the queue.
`timescale 1ns / 1ps
module pixel_gain_whitebalance_dither_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chan_blue, chan_green, chan_red
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_blue, out_green, out_red
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  pgwd_pkg::cfg_t  cfg;
  pgwd_pkg::item_t fitem, qitem;
  logic cfg_write, push, pop, qfull, qne;
  logic [2:0] qcount;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= 13'd1024;
      cfg.image_height    <= 13'd1024;
      cfg.color_mode      <= 1'b0;
      cfg.gain_constant   <= 16'd4096;
      cfg.gain_x_terms    <= '0;
      cfg.gain_y_terms    <= '0;
      cfg.channel_gains   <= 48'h1000_1000_1000;
      cfg.channel_offsets <= '0;
    end else if (cfg_write) begin
      case (pgwd_pkg::reg_index_t'(cfg_index))
        pgwd_pkg::REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[12:0];
        pgwd_pkg::REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[12:0];
        pgwd_pkg::REG_COLOR_MODE:      cfg.color_mode      <= cfg_data[0];
        pgwd_pkg::REG_GAIN_CONSTANT:   cfg.gain_constant   <= cfg_data[15:0];
        pgwd_pkg::REG_GAIN_X_TERMS:    cfg.gain_x_terms    <= cfg_data[31:0];
        pgwd_pkg::REG_GAIN_Y_TERMS:    cfg.gain_y_terms    <= cfg_data[31:0];
        pgwd_pkg::REG_CHANNEL_GAINS:   cfg.channel_gains   <= cfg_data;
        pgwd_pkg::REG_CHANNEL_OFFSETS: cfg.channel_offsets <= cfg_data;
        default: ;
      endcase
    end
  end

  pgwd_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .cfg_write(cfg_write),
    .in_valid(s_axis_tvalid), .in_pix(s_axis_tdata), .in_ready(s_axis_tready),
    .q_full(qfull), .push(push), .item(fitem)
  );

  pgwd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(fitem), .pop(pop), .dout(qitem),
    .full(qfull), .nonempty(qne), .count(qcount)
  );

  pgwd_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_nonempty(qne), .q_item(qitem), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_pix(m_axis_tdata),
    .out_last(m_axis_tlast)
  );

  a_qbound: assert property (@(posedge clk) disable iff (rst)
    qcount <= 3'(pgwd_pkg::QDEPTH)) else $error("queue overflow");
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !s_axis_tready) else $error("input taken during divider restart");
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !cfg.color_mode |-> m_axis_tdata[23:8] == 16'd0)
    else $error("gray mode with nonzero color");
endmodule
